>>> design/ise_pkg.sv
package ise_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 100;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // datapath
  localparam int DATA_W    = 32;
  localparam int LIT_W     = 31;
  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [LIT_W-1:0] LIT_MAX = {LIT_W{1'b1}};

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OPERANDS = 2'd1,
    ERR_DIVZERO  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENDLIT,
    ST_RD_Y,
    ST_RD_X,
    ST_EXEC,
    ST_DIV_WAIT,
    ST_POST,
    ST_RD_TOP,
    ST_OUT_WAIT
  } st_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_res_t;

endpackage

>>> design/ise_ram.sv
module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; rdata holds when not reading
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ise_div.sv
module ise_div (
  input  logic             clk,
  input  logic             rst,
  input  ise_pkg::div_req_t req,
  output ise_pkg::div_res_t res
);

  logic                          busy;
  logic                          done;
  logic                          neg;
  logic [ise_pkg::STEP_W-1:0]    steps;
  logic [ise_pkg::DATA_W-1:0]    rem;
  logic [ise_pkg::DATA_W-1:0]    quo;
  logic [ise_pkg::DATA_W-1:0]    dvs;

  logic [ise_pkg::DATA_W-1:0]    abs_x;
  logic [ise_pkg::DATA_W-1:0]    abs_y;
  logic [ise_pkg::DATA_W:0]      trial;
  logic [ise_pkg::DATA_W:0]      diff;
  logic                          fits;

  // magnitudes of the operands; the most negative value maps onto itself
  assign abs_x = req.dividend[ise_pkg::DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign abs_y = req.divisor[ise_pkg::DATA_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;

  // one restoring step: shift in the next dividend bit, try to subtract
  assign trial = {rem, quo[ise_pkg::DATA_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = ~diff[ise_pkg::DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= ise_pkg::STEP_W'(ise_pkg::DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == ise_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[ise_pkg::DATA_W-1] ^ req.divisor[ise_pkg::DATA_W-1];
      rem <= '0;
      quo <= abs_x;
      dvs <= abs_y;
    end else if (busy) begin
      rem <= fits ? diff[ise_pkg::DATA_W-1:0] : trial[ise_pkg::DATA_W-1:0];
      quo <= {quo[ise_pkg::DATA_W-2:0], fits};
    end
  end

  assign res.done = done;
  assign res.quot = neg ? (~quo + 1'b1) : quo;

endmodule

>>> design/infix_stack_expression_evaluator.sv
// Sequencing: a digit word without tlast is taken in idle, as is any word after an error that
//   lacks tlast; other words run the sequencer, and a division the 32-step divider.
//   tlast adds a read of the stack top and a load of the output register, which waits while full.
// tready is low while an item is worked on, so no new word is taken until the sequencer is idle.
// Reset (rst, synchronous, active high) empties both stacks, clears the literal and error,
//   and drops any result held in the output register.
module infix_stack_expression_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] value, [33:32] status, [39:34] zero
);

  localparam int DW = ise_pkg::DATA_W;
  localparam int CW = ise_pkg::CNT_W;
  localparam int PW = ise_pkg::PTR_W;

  // control state
  ise_pkg::st_t            state, state_next;
  ise_pkg::err_t           err, err_next;
  logic [CW-1:0]           opd_cnt, opd_cnt_next;
  logic [CW-1:0]           opr_cnt, opr_cnt_next;
  logic                    in_lit, in_lit_next;
  logic                    fin, fin_next;
  logic                    last_r, last_r_next;
  logic                    out_valid, out_valid_next;

  // payload state
  logic [ise_pkg::LIT_W-1:0] acc, acc_next;
  logic                    pend_vld, pend_vld_next;
  ise_pkg::op_t            pend_op, pend_op_next;
  ise_pkg::op_t            op_r, op_r_next;
  logic [DW-1:0]           y_r, y_r_next;
  logic                    has_top, has_top_next;
  logic [DW-1:0]           out_value, out_value_next;
  ise_pkg::err_t           out_status, out_status_next;

  // memory ports
  logic                    opd_we, opd_re;
  logic [PW-1:0]           opd_waddr, opd_raddr;
  logic [DW-1:0]           opd_wdata, opd_rdata;
  logic                    opr_we, opr_re;
  logic [PW-1:0]           opr_waddr, opr_raddr;
  logic [1:0]              opr_wdata, opr_rdata;

  ise_pkg::div_req_t       div_req;
  ise_pkg::div_res_t       div_res;

  // helpers
  logic                    accept;
  logic                    is_digit;
  logic [ise_pkg::LIT_W+3:0] lit_wide;
  logic [CW-1:0]           opd_m1, opd_m2, opr_m1;
  logic [DW-1:0]           x_val, sum_val, dif_val, prod_val;

  assign s_axis_tready = (state == ise_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_digit      = (s_axis_tdata >= ise_pkg::CH_ZERO) && (s_axis_tdata <= ise_pkg::CH_NINE);

  // acc * 10 + digit, saturated below
  assign lit_wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
                  + {{ise_pkg::LIT_W{1'b0}}, s_axis_tdata[3:0]};

  assign opd_m1 = opd_cnt - CW'(1);
  assign opd_m2 = opd_cnt - CW'(2);
  assign opr_m1 = opr_cnt - CW'(1);

  // shared ALU: x comes straight from the stack read register
  assign x_val    = opd_rdata;
  assign sum_val  = x_val + y_r;
  assign dif_val  = x_val - y_r;
  assign prod_val = x_val * y_r;

  ise_ram #(.WIDTH(DW), .DEPTH(ise_pkg::STACK_DEPTH)) u_opd_ram (
    .clk   (clk),
    .we    (opd_we),
    .waddr (opd_waddr),
    .wdata (opd_wdata),
    .re    (opd_re),
    .raddr (opd_raddr),
    .rdata (opd_rdata)
  );

  ise_ram #(.WIDTH(2), .DEPTH(ise_pkg::STACK_DEPTH)) u_opr_ram (
    .clk   (clk),
    .we    (opr_we),
    .waddr (opr_waddr),
    .wdata (opr_wdata),
    .re    (opr_re),
    .raddr (opr_raddr),
    .rdata (opr_rdata)
  );

  ise_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ise_pkg::ST_IDLE;
      err       <= ise_pkg::ERR_NONE;
      opd_cnt   <= '0;
      opr_cnt   <= '0;
      in_lit    <= 1'b0;
      fin       <= 1'b0;
      last_r    <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      state     <= state_next;
      err       <= err_next;
      opd_cnt   <= opd_cnt_next;
      opr_cnt   <= opr_cnt_next;
      in_lit    <= in_lit_next;
      fin       <= fin_next;
      last_r    <= last_r_next;
      out_valid <= out_valid_next;
      acc       <= acc_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_vld   <= pend_vld_next;
    pend_op    <= pend_op_next;
    op_r       <= op_r_next;
    y_r        <= y_r_next;
    has_top    <= has_top_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    err_next        = err;
    opd_cnt_next    = opd_cnt;
    opr_cnt_next    = opr_cnt;
    in_lit_next     = in_lit;
    fin_next        = fin;
    last_r_next     = last_r;
    acc_next        = acc;
    pend_vld_next   = pend_vld;
    pend_op_next    = pend_op;
    op_r_next       = op_r;
    y_r_next        = y_r;
    has_top_next    = has_top;
    out_value_next  = out_value;
    out_status_next = out_status;
    out_valid_next  = out_valid && !m_axis_tready;

    opd_we    = 1'b0;
    opd_waddr = opd_cnt[PW-1:0];
    opd_wdata = {{(DW - ise_pkg::LIT_W){1'b0}}, acc};
    opd_re    = 1'b0;
    opd_raddr = opd_m1[PW-1:0];
    opr_we    = 1'b0;
    opr_waddr = opr_cnt[PW-1:0];
    opr_wdata = pend_op;
    opr_re    = 1'b0;
    opr_raddr = opr_m1[PW-1:0];

    div_req.start    = 1'b0;
    div_req.dividend = x_val;
    div_req.divisor  = y_r;

    unique case (state)
      ise_pkg::ST_IDLE: begin
        if (accept) begin
          last_r_next = s_axis_tlast;
          fin_next    = 1'b0;
          if (err != ise_pkg::ERR_NONE) begin
            // errored expression: swallow words until the last one
            state_next = s_axis_tlast ? ise_pkg::ST_RD_TOP : ise_pkg::ST_IDLE;
          end else if (is_digit) begin
            acc_next    = (lit_wide > {4'b0, ise_pkg::LIT_MAX}) ? ise_pkg::LIT_MAX
                                                                : lit_wide[ise_pkg::LIT_W-1:0];
            in_lit_next = 1'b1;
            if (s_axis_tlast) begin
              fin_next   = 1'b1;
              state_next = ise_pkg::ST_ENDLIT;
            end
          end else begin
            pend_vld_next = 1'b1;
            pend_op_next  = ise_pkg::OP_ADD;
            priority case (s_axis_tdata)
              ise_pkg::CH_PLUS:  pend_op_next = ise_pkg::OP_ADD;
              ise_pkg::CH_MINUS: pend_op_next = ise_pkg::OP_SUB;
              ise_pkg::CH_STAR:  pend_op_next = ise_pkg::OP_MUL;
              ise_pkg::CH_SLASH: pend_op_next = ise_pkg::OP_DIV;
              default:           pend_vld_next = 1'b0;
            endcase
            state_next = ise_pkg::ST_ENDLIT;
          end
        end
      end

      // close an open literal, push it, pop a pending operator
      ise_pkg::ST_ENDLIT: begin
        state_next = ise_pkg::ST_POST;
        if (in_lit) begin
          in_lit_next = 1'b0;
          acc_next    = '0;
          if (opd_cnt < CW'(ise_pkg::STACK_DEPTH)) begin
            opd_we       = 1'b1;
            opd_cnt_next = opd_cnt + CW'(1);
          end
          if (opr_cnt != '0) begin
            opr_re       = 1'b1;
            opr_cnt_next = opr_m1;
            state_next   = ise_pkg::ST_RD_Y;
          end
        end
      end

      ise_pkg::ST_RD_Y: begin
        op_r_next = ise_pkg::op_t'(opr_rdata);
        if (opd_cnt < CW'(2)) begin
          err_next   = ise_pkg::ERR_OPERANDS;
          state_next = ise_pkg::ST_POST;
        end else begin
          opd_re     = 1'b1;
          opd_raddr  = opd_m1[PW-1:0];
          state_next = ise_pkg::ST_RD_X;
        end
      end

      ise_pkg::ST_RD_X: begin
        y_r_next   = opd_rdata;
        opd_re     = 1'b1;
        opd_raddr  = opd_m2[PW-1:0];
        state_next = ise_pkg::ST_EXEC;
      end

      ise_pkg::ST_EXEC: begin
        opd_waddr  = opd_m2[PW-1:0];
        state_next = ise_pkg::ST_POST;
        unique case (op_r)
          ise_pkg::OP_ADD: begin
            opd_we       = 1'b1;
            opd_wdata    = sum_val;
            opd_cnt_next = opd_m1;
          end
          ise_pkg::OP_SUB: begin
            opd_we       = 1'b1;
            opd_wdata    = dif_val;
            opd_cnt_next = opd_m1;
          end
          ise_pkg::OP_MUL: begin
            opd_we       = 1'b1;
            opd_wdata    = prod_val;
            opd_cnt_next = opd_m1;
          end
          ise_pkg::OP_DIV: begin
            if (y_r == '0) begin
              err_next = ise_pkg::ERR_DIVZERO;
            end else begin
              div_req.start = 1'b1;
              state_next    = ise_pkg::ST_DIV_WAIT;
            end
          end
        endcase
      end

      ise_pkg::ST_DIV_WAIT: begin
        opd_waddr = opd_m2[PW-1:0];
        opd_wdata = div_res.quot;
        if (div_res.done) begin
          opd_we       = 1'b1;
          opd_cnt_next = opd_m1;
          state_next   = ise_pkg::ST_POST;
        end
      end

      // push the operator of this word, then finish or wait for the next
      ise_pkg::ST_POST: begin
        if (fin) begin
          state_next = ise_pkg::ST_RD_TOP;
        end else begin
          if (err == ise_pkg::ERR_NONE && pend_vld &&
              opr_cnt < CW'(ise_pkg::STACK_DEPTH)) begin
            opr_we       = 1'b1;
            opr_cnt_next = opr_cnt + CW'(1);
          end
          state_next = last_r ? ise_pkg::ST_RD_TOP : ise_pkg::ST_IDLE;
        end
      end

      ise_pkg::ST_RD_TOP: begin
        has_top_next = (err == ise_pkg::ERR_NONE) && (opd_cnt != '0);
        opd_re       = has_top_next;
        opd_raddr    = opd_m1[PW-1:0];
        state_next   = ise_pkg::ST_OUT_WAIT;
      end

      // load the result once the output register is free, then clear
      ise_pkg::ST_OUT_WAIT: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next  = 1'b1;
          out_value_next  = has_top ? opd_rdata : '0;
          out_status_next = err;
          err_next        = ise_pkg::ERR_NONE;
          opd_cnt_next    = '0;
          opr_cnt_next    = '0;
          in_lit_next     = 1'b0;
          acc_next        = '0;
          state_next      = ise_pkg::ST_IDLE;
        end
      end

      default: state_next = ise_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_status, out_value};

  // checks
  a_opd_bound: assert property (@(posedge clk) disable iff (rst)
    opd_cnt <= CW'(ise_pkg::STACK_DEPTH))
    else $error("operand count past stack depth");

  a_opr_bound: assert property (@(posedge clk) disable iff (rst)
    opr_cnt <= CW'(ise_pkg::STACK_DEPTH))
    else $error("operator count past stack depth");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[33:32] != ise_pkg::ERR_NONE) |-> (m_axis_tdata[31:0] == '0))
    else $error("error result carries a nonzero value");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ise_pkg::ST_DIV_WAIT))
    else $error("divider finished outside a division");

endmodule
